/* rtl/mstp_pkg.sv */
// ----------------------------------------------------------------------------
// mstp_pkg
// Shared types and constants for the Prim spanning tree unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mstp_pkg;

  localparam int VERTEX_COUNT_DEF = 64;
  localparam int WEIGHT_BITS_DEF  = 32;
  localparam int VID_W            = 6;
  localparam int EDGE_W           = 32;
  localparam int COST_W           = 38;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_RUN   = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_LD_RD,
    ST_LD_CMP,
    ST_LD_WR2,
    ST_RUN_INIT,
    ST_SCAN,
    ST_UPD
  } state_t;

endpackage

/* rtl/mstp_ram.sv */
// ----------------------------------------------------------------------------
// mstp_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mstp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/minimum_spanning_tree_prim_unit.sv */
// ----------------------------------------------------------------------------
// minimum_spanning_tree_prim_unit
// Dense weight matrix edge store with an iterative Prim tree builder.
// ----------------------------------------------------------------------------
// channel   direction  handshake          ports
// in        input      start & !busy      in_op, in_vertex_a, in_vertex_b,
//                                         in_edge_weight
// out       output     out_valid strobe   out_tree_vertex, out_tree_parent,
//                                         out_link_weight, out_total_cost,
//                                         out_last
//
// Load: read, compare with the first write, second write; when the stored
// weight is kept, no write is made. Clear writes zero to every matrix entry.
// Run: one scan of the candidate RAM and one pass over a matrix row per
// vertex joined, one entry a cycle, and a final scan that finds nothing.
// Reset starts a clearing pass of the matrix RAM; busy stays high.
// Results are strobed for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module minimum_spanning_tree_prim_unit import mstp_pkg::*; #(
  parameter int VERTEX_COUNT = VERTEX_COUNT_DEF,
  parameter int WEIGHT_BITS  = WEIGHT_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               in_op,
  input  logic [VID_W-1:0]         in_vertex_a,
  input  logic [VID_W-1:0]         in_vertex_b,
  input  logic signed [EDGE_W-1:0] in_edge_weight,
  output logic                     out_valid,
  output logic [VID_W-1:0]         out_tree_vertex,
  output logic [VID_W-1:0]         out_tree_parent,
  output logic signed [EDGE_W-1:0] out_link_weight,
  output logic signed [COST_W-1:0] out_total_cost,
  output logic                     out_last
);

  localparam int VB  = $clog2(VERTEX_COUNT);
  localparam int MAW = $clog2(VERTEX_COUNT * VERTEX_COUNT);
  localparam int IW  = $clog2(VERTEX_COUNT + 1);
  localparam int MW  = WEIGHT_BITS + 1;
  localparam int BW  = WEIGHT_BITS + VB;

  state_t state_r, state_nxt;

  logic [VB-1:0]                 a_r, b_r;
  logic signed [WEIGHT_BITS-1:0] w_r;
  logic [MAW-1:0]                clr_r;
  logic [IW-1:0]                 idx_r;
  logic [VB-1:0]                 pidx_r;
  logic [VERTEX_COUNT-1:0]       intree_r, cvalid_r;
  logic                          found_r;
  logic [VB-1:0]                 pick_r, ppar_r;
  logic signed [WEIGHT_BITS-1:0] pw_r;
  logic [MAW-1:0]                row_r;
  logic signed [COST_W-1:0]      cost_r;
  logic                          pend_vld_r;
  logic [VB-1:0]                 pend_v_r, pend_p_r;
  logic signed [WEIGHT_BITS-1:0] pend_w_r;
  logic signed [COST_W-1:0]      pend_c_r;

  logic                          out_valid_r, out_last_r;
  logic [VID_W-1:0]              out_v_r, out_p_r;
  logic signed [EDGE_W-1:0]      out_w_r;
  logic signed [COST_W-1:0]      out_c_r;

  logic             m_we;
  logic [MAW-1:0]   m_waddr, m_raddr;
  logic [MW-1:0]    m_wdata, m_rdata;
  logic             b_we;
  logic [VB-1:0]    b_waddr, b_raddr;
  logic [BW-1:0]    b_wdata, b_rdata;

  logic                          accept;
  logic                          a_ok, b_ok;
  logic [MAW-1:0]                ab_addr, ba_addr;
  logic signed [WEIGHT_BITS-1:0] in_w;
  logic signed [WEIGHT_BITS-1:0] old_w, bw, ew;
  logic [VB-1:0]                 bpar;
  logic                          ld_upd, scan_take, upd_take, idx_end, clr_end;
  logic                          found_c;
  logic [VB-1:0]                 pick_c, par_c;
  logic signed [WEIGHT_BITS-1:0] pw_c;
  logic signed [COST_W-1:0]      cost_c;

  mstp_ram #(.WIDTH(MW), .DEPTH(VERTEX_COUNT * VERTEX_COUNT)) u_matrix (
    .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
    .raddr(m_raddr), .rdata(m_rdata)
  );

  mstp_ram #(.WIDTH(BW), .DEPTH(VERTEX_COUNT)) u_best (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
    .raddr(b_raddr), .rdata(b_rdata)
  );

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;
  assign a_ok   = ({1'b0, in_vertex_a} < (VID_W+1)'(VERTEX_COUNT));
  assign b_ok   = ({1'b0, in_vertex_b} < (VID_W+1)'(VERTEX_COUNT));
  assign in_w   = in_edge_weight[WEIGHT_BITS-1:0];

  assign ab_addr = MAW'(a_r) * MAW'(VERTEX_COUNT) + MAW'(b_r);
  assign ba_addr = MAW'(b_r) * MAW'(VERTEX_COUNT) + MAW'(a_r);
  assign idx_end = (idx_r == IW'(VERTEX_COUNT));
  assign clr_end = (clr_r == MAW'(VERTEX_COUNT * VERTEX_COUNT - 1));

  assign old_w  = m_rdata[WEIGHT_BITS-1:0];
  assign ld_upd = !m_rdata[WEIGHT_BITS] || (w_r < old_w);

  assign bw   = b_rdata[WEIGHT_BITS-1:0];
  assign bpar = b_rdata[BW-1:WEIGHT_BITS];
  assign ew   = m_rdata[WEIGHT_BITS-1:0];

  assign scan_take = (idx_r != '0) && !intree_r[pidx_r] && cvalid_r[pidx_r] &&
                     (!found_r || (bw < pw_r));
  assign upd_take  = (idx_r != '0) && !intree_r[pidx_r] && m_rdata[WEIGHT_BITS] &&
                     (!cvalid_r[pidx_r] || (ew < bw));

  assign found_c = found_r || scan_take;
  assign pick_c  = scan_take ? pidx_r : pick_r;
  assign par_c   = scan_take ? bpar : ppar_r;
  assign pw_c    = scan_take ? bw : pw_r;
  assign cost_c  = cost_r + COST_W'(pw_c);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLR:      if (clr_end) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          case (in_op)
            OP_LOAD:  if (a_ok && b_ok && (in_vertex_a != in_vertex_b))
                        state_nxt = ST_LD_RD;
            OP_RUN:   if (a_ok) state_nxt = ST_RUN_INIT;
            OP_CLEAR: state_nxt = ST_CLR;
            default:  state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_LD_RD:    state_nxt = ST_LD_CMP;
      ST_LD_CMP:   state_nxt = ld_upd ? ST_LD_WR2 : ST_IDLE;
      ST_LD_WR2:   state_nxt = ST_IDLE;
      ST_RUN_INIT: state_nxt = ST_SCAN;
      ST_SCAN:     if (idx_end) state_nxt = found_c ? ST_UPD : ST_IDLE;
      ST_UPD:      if (idx_end) state_nxt = ST_SCAN;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // memory port control
  always_comb begin
    m_we    = 1'b0;
    m_waddr = ab_addr;
    m_wdata = {1'b1, w_r};
    m_raddr = ab_addr;
    b_we    = 1'b0;
    b_waddr = pidx_r;
    b_wdata = {pick_r, ew};
    b_raddr = idx_r[VB-1:0];
    unique case (state_r)
      ST_CLR: begin
        m_we    = 1'b1;
        m_waddr = clr_r;
        m_wdata = '0;
      end
      ST_LD_CMP:   m_we = ld_upd;
      ST_LD_WR2: begin
        m_we    = 1'b1;
        m_waddr = ba_addr;
      end
      ST_RUN_INIT: begin
        b_we    = 1'b1;
        b_waddr = a_r;
        b_wdata = {a_r, {WEIGHT_BITS{1'b0}}};
      end
      ST_UPD: begin
        m_raddr = row_r + MAW'(idx_r[VB-1:0]);
        b_we    = upd_take;
      end
      default: begin
        m_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      pend_vld_r  <= 1'b0;
      found_r     <= 1'b0;
      idx_r       <= '0;
      intree_r    <= '0;
      cvalid_r    <= '0;
      cost_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == ST_SCAN) && idx_end && pend_vld_r;
      pidx_r      <= idx_r[VB-1:0];
      unique case (state_r)
        ST_CLR:  clr_r <= clr_r + MAW'(1);
        ST_IDLE: begin
          clr_r <= '0;
          if (accept) begin
            a_r <= in_vertex_a[VB-1:0];
            b_r <= in_vertex_b[VB-1:0];
            w_r <= in_w;
          end
        end
        ST_RUN_INIT: begin
          intree_r   <= '0;
          cvalid_r   <= VERTEX_COUNT'(1) << a_r;
          cost_r     <= '0;
          pend_vld_r <= 1'b0;
          found_r    <= 1'b0;
          idx_r      <= '0;
        end
        ST_SCAN: begin
          found_r <= found_c;
          pick_r  <= pick_c;
          ppar_r  <= par_c;
          pw_r    <= pw_c;
          idx_r   <= idx_end ? '0 : idx_r + IW'(1);
          if (idx_end) begin
            if (pend_vld_r) begin
              out_last_r  <= !found_c;
              out_v_r     <= VID_W'(pend_v_r);
              out_p_r     <= VID_W'(pend_p_r);
              out_w_r     <= EDGE_W'(pend_w_r);
              out_c_r     <= pend_c_r;
            end
            pend_vld_r <= found_c;
            if (found_c) begin
              intree_r[pick_c] <= 1'b1;
              cost_r   <= cost_c;
              pend_v_r <= pick_c;
              pend_p_r <= par_c;
              pend_w_r <= pw_c;
              pend_c_r <= cost_c;
              row_r    <= MAW'(pick_c) * MAW'(VERTEX_COUNT);
            end
          end
        end
        ST_UPD: begin
          idx_r <= idx_end ? '0 : idx_r + IW'(1);
          if (upd_take) cvalid_r[pidx_r] <= 1'b1;
          if (idx_end) begin
            found_r <= 1'b0;
          end
        end
        default: begin
          clr_r <= clr_r;
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_last        = out_last_r;
  assign out_tree_vertex = out_v_r;
  assign out_tree_parent = out_p_r;
  assign out_link_weight = out_w_r;
  assign out_total_cost  = out_c_r;

  a_out_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == ST_SCAN))
    else $error("result strobe not preceded by a scan end");

  a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_op == OP_CLEAR) |=> (busy && state_r == ST_CLR))
    else $error("clear item did not start a clearing pass");

  a_tree_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPD && $past(state_r) == ST_SCAN) |->
      ($countones(intree_r) == $countones($past(intree_r)) + 1))
    else $error("tree did not grow by one vertex");

  a_pick_in_tree: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_UPD |-> intree_r[pick_r])
    else $error("picked vertex not marked in tree during update");

endmodule
